>>> rtl/sssd_pkg.sv
// ----------------------------------------------------------------------------
// sssd_pkg - shared types, constants and functions for the scan display
// Glyph codes, event kinds, register indexes and the glyph segment table.
// ----------------------------------------------------------------------------
package sssd_pkg;

   localparam int DIGIT_COUNT = 4;
   localparam int SCAN_W      = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

   localparam logic [3:0] GLYPH_DASH  = 4'd10;
   localparam logic [3:0] GLYPH_U     = 4'd11;
   localparam logic [3:0] GLYPH_BLANK = 4'd14;

   localparam logic [2:0] LAMP_IDLE = 3'd7;
   localparam logic [9:0] HOLD_MAX  = 10'd1023;

   localparam logic [9:0] HOLD_LIMIT_RESET = 10'd800;
   localparam logic [2:0] LAMP_TICKS_RESET = 3'd5;

   // Reciprocals scaled by 2^24; exact for any 13-bit card number.
   localparam int          RECIP_SHIFT = 24;
   localparam logic [20:0] RECIP_10    = 21'd1677722;
   localparam logic [20:0] RECIP_100   = 21'd167773;
   localparam logic [20:0] RECIP_1000  = 21'd16778;

   typedef logic [3:0] glyph_type;
   typedef glyph_type digits_type [DIGIT_COUNT];

   typedef enum logic [2:0] {
      KIND_TICK    = 3'd0,
      KIND_CARD    = 3'd1,
      KIND_RX      = 3'd2,
      KIND_TX      = 3'd3,
      KIND_VERSION = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      CSR_HOLD_LIMIT   = 2'd0,
      CSR_LAMP_TICKS   = 2'd1,
      CSR_VERSION_LOW  = 2'd2,
      CSR_VERSION_HIGH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] digit_select;
      logic [7:0] segments;
      logic       rx_lamp_on;
      logic       tx_lamp_on;
      logic       read_lamp_on;
   } rsp_type;

   typedef struct packed {
      logic [2:0] count;
      logic       on;
   } lamp_type;

   // Active-low segment pattern of a glyph code; codes 14 and 15 are blank.
   function automatic logic [7:0] glyph_segments(input glyph_type code);
      logic [7:0] seg;
      case (code)
         4'd0:    seg = 8'hC0;
         4'd1:    seg = 8'hF9;
         4'd2:    seg = 8'hA4;
         4'd3:    seg = 8'hB0;
         4'd4:    seg = 8'h99;
         4'd5:    seg = 8'h92;
         4'd6:    seg = 8'h82;
         4'd7:    seg = 8'hF8;
         4'd8:    seg = 8'h80;
         4'd9:    seg = 8'h90;
         4'd10:   seg = 8'hBF;
         4'd11:   seg = 8'hC1;
         4'd12:   seg = 8'h86;
         4'd13:   seg = 8'h88;
         default: seg = 8'hFF;
      endcase
      return seg;
   endfunction

   // Advance a lamp stretcher by one tick.
   function automatic lamp_type lamp_step(input logic [2:0] count,
                                          input logic [2:0] ticks);
      lamp_type r;
      if (count < ticks) begin
         r.count = count + 3'd1;
         r.on    = 1'b1;
      end else begin
         r.count = LAMP_IDLE;
         r.on    = 1'b0;
      end
      return r;
   endfunction

endpackage

>>> rtl/seven_segment_scan_display.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_display - multiplexed four-digit display and lamp driver
// Keeps the shown digits and three lamp stretchers; each tick emits one
// scanned digit's select and segment bytes together with the lamp states.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : event transfers (tick, card read, receive, transmit, version).
//            Only a tick produces a result; other known kinds update state.
//   rsp_*  : one result transfer per tick: active-low select and segment
//            bytes for the scanned digit plus the three lamp flags.
//   csr_*  : register writes, always ready; write only while the block idles.
// Timing: an event's state update lands on the edge that accepts it; a tick's
//   result is registered in the output register, or in the skid register if
//   the output waits. One event per cycle is taken while req_stall is low.
// Stalls: results sit in an output register backed by a one-entry skid
//   register, so the block keeps taking events while a result waits.
//   req_stall rises only when both are full and comes from a flop.
// Reset: digits show dashes, hold counter and scan position clear, lamps go
//   idle, registers return to hold 800, lamp 5, version glyphs 0.
// ----------------------------------------------------------------------------
module seven_segment_scan_display
   import sssd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [12:0] req_card_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_digit_select,
   output logic [7:0]  rsp_segments,
   output logic        rsp_rx_lamp_on,
   output logic        rsp_tx_lamp_on,
   output logic        rsp_read_lamp_and_buzzer_on,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_wdata
);

   // Configuration registers
   logic [9:0] hold_limit_ff;
   logic [2:0] lamp_ticks_ff;
   glyph_type  version_low_ff;
   glyph_type  version_high_ff;

   // Display and lamp state
   digits_type  shown_ff, shown_in;
   digits_type  prev_ff, prev_in;
   logic [9:0]  hold_ff, hold_in;
   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic [2:0]  rx_ff, rx_in;
   logic [2:0]  tx_ff, tx_in;
   logic [2:0]  read_ff, read_in;

   // Output register and skid register
   rsp_type out_ff, out_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type skid_ff, skid_in;
   logic    skid_valid_ff, skid_valid_in;

   logic    req_accept;
   logic    rsp_pop;
   logic    push;
   rsp_type tick_rsp;

   // Card number split into decimal digits
   logic [33:0] prod_10, prod_100, prod_1000;
   logic [9:0]  quot_10, quot_100, quot_1000;
   logic [12:0] rem_0, rem_1, rem_2;
   digits_type  card_digits;

   // Tick-side values
   logic        same_digits;
   logic [9:0]  hold_inc;
   logic        blank_now;
   digits_type  tick_shown;
   lamp_type    rx_step, tx_step, read_step;

   assign csr_ready  = 1'b1;
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_valid  = out_valid_ff;
   assign rsp_pop    = out_valid_ff & ~rsp_stall;

   assign rsp_digit_select            = out_ff.digit_select;
   assign rsp_segments                = out_ff.segments;
   assign rsp_rx_lamp_on              = out_ff.rx_lamp_on;
   assign rsp_tx_lamp_on              = out_ff.tx_lamp_on;
   assign rsp_read_lamp_and_buzzer_on = out_ff.read_lamp_on;

   // Divide by 10, 100 and 1000 through scaled reciprocals.
   assign prod_10   = 34'(req_card_id) * 34'(RECIP_10);
   assign prod_100  = 34'(req_card_id) * 34'(RECIP_100);
   assign prod_1000 = 34'(req_card_id) * 34'(RECIP_1000);
   assign quot_10   = prod_10[RECIP_SHIFT +: 10];
   assign quot_100  = prod_100[RECIP_SHIFT +: 10];
   assign quot_1000 = prod_1000[RECIP_SHIFT +: 10];

   assign rem_0 = req_card_id - 13'(quot_10) * 13'd10;
   assign rem_1 = 13'(quot_10) - 13'(quot_100) * 13'd10;
   assign rem_2 = 13'(quot_100) - 13'(quot_1000) * 13'd10;

   always_comb begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         case (i)
            0:       card_digits[i] = rem_0[3:0];
            1:       card_digits[i] = rem_1[3:0];
            2:       card_digits[i] = rem_2[3:0];
            3:       card_digits[i] = quot_1000[3:0];
            default: card_digits[i] = 4'd0;
         endcase
      end
   end

   // Hold check: count unchanged ticks, blank to dashes past the limit.
   always_comb begin
      same_digits = 1'b1;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (shown_ff[i] != prev_ff[i]) begin
            same_digits = 1'b0;
         end
      end
   end

   assign hold_inc  = (hold_ff < HOLD_MAX) ? hold_ff + 10'd1 : hold_ff;
   assign blank_now = same_digits && (hold_inc > hold_limit_ff);

   always_comb begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         tick_shown[i] = blank_now ? GLYPH_DASH : shown_ff[i];
      end
   end

   assign rx_step   = lamp_step(rx_ff, lamp_ticks_ff);
   assign tx_step   = lamp_step(tx_ff, lamp_ticks_ff);
   assign read_step = lamp_step(read_ff, lamp_ticks_ff);

   // Result of a tick: the scanned digit uses the digits after the hold check.
   always_comb begin
      tick_rsp.digit_select = ~(8'd1 << scan_ff);
      tick_rsp.segments     = glyph_segments(tick_shown[scan_ff]);
      tick_rsp.rx_lamp_on   = rx_step.on;
      tick_rsp.tx_lamp_on   = tx_step.on;
      tick_rsp.read_lamp_on = read_step.on;
   end

   // Next state per event kind
   always_comb begin
      shown_in = shown_ff;
      prev_in  = prev_ff;
      hold_in  = hold_ff;
      scan_in  = scan_ff;
      rx_in    = rx_ff;
      tx_in    = tx_ff;
      read_in  = read_ff;
      push     = 1'b0;
      if (req_accept) begin
         case (req_kind)
            KIND_TICK: begin
               push     = 1'b1;
               shown_in = tick_shown;
               prev_in  = tick_shown;
               if (!same_digits) begin
                  hold_in = 10'd0;
               end else if (blank_now) begin
                  hold_in = hold_limit_ff + 10'd1;
               end else begin
                  hold_in = hold_inc;
               end
               rx_in   = rx_step.count;
               tx_in   = tx_step.count;
               read_in = read_step.count;
               if (scan_ff == SCAN_W'(DIGIT_COUNT - 1)) begin
                  scan_in = '0;
               end else begin
                  scan_in = scan_ff + SCAN_W'(1);
               end
            end
            KIND_CARD: begin
               shown_in = card_digits;
               hold_in  = 10'd0;
               read_in  = 3'd0;
            end
            KIND_RX: begin
               rx_in = 3'd0;
            end
            KIND_TX: begin
               tx_in = 3'd0;
            end
            KIND_VERSION: begin
               for (int i = 0; i < DIGIT_COUNT; i++) begin
                  if (i == 0) begin
                     shown_in[i] = version_low_ff;
                  end else if (i == 2) begin
                     shown_in[i] = version_high_ff;
                  end else if (i == 1 || i == 3) begin
                     shown_in[i] = GLYPH_U;
                  end else begin
                     shown_in[i] = GLYPH_BLANK;
                  end
               end
            end
            default: ; // unknown kinds drop without effect
         endcase
      end
   end

   // Output register with skid: the skid only fills while the output waits.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = tick_rsp;
            out_valid_in = push;
         end
      end else if (!out_valid_ff) begin
         out_in       = tick_rsp;
         out_valid_in = push;
      end else if (push) begin
         skid_in       = tick_rsp;
         skid_valid_in = 1'b1;
      end
   end

   // State and control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            shown_ff[i] <= GLYPH_DASH;
            prev_ff[i]  <= GLYPH_DASH;
         end
         hold_ff       <= 10'd0;
         scan_ff       <= '0;
         rx_ff         <= LAMP_IDLE;
         tx_ff         <= LAMP_IDLE;
         read_ff       <= LAMP_IDLE;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         shown_ff      <= shown_in;
         prev_ff       <= prev_in;
         hold_ff       <= hold_in;
         scan_ff       <= scan_in;
         rx_ff         <= rx_in;
         tx_ff         <= tx_in;
         read_ff       <= read_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload flops: no reset needed
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // Register writes: keep only the low bits each register holds.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_limit_ff   <= HOLD_LIMIT_RESET;
         lamp_ticks_ff   <= LAMP_TICKS_RESET;
         version_low_ff  <= 4'd0;
         version_high_ff <= 4'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HOLD_LIMIT:   hold_limit_ff   <= csr_wdata;
            CSR_LAMP_TICKS:   lamp_ticks_ff   <= csr_wdata[2:0];
            CSR_VERSION_LOW:  version_low_ff  <= csr_wdata[3:0];
            CSR_VERSION_HIGH: version_high_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

endmodule

>>> tb/sv/seven_segment_scan_display_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seven_segment_scan_display_test - self-checking bench for the scan display
// Drives display events with random sender gaps and result stalls and
// predicts every tick result in a behavioural model of the display. It
// covers the digit scan, the lamp stretchers at their extreme settings, the
// version pattern, blanking after the hold limit, counter saturation and
// ignored event codes. The model is reconfigured between phases.
// ----------------------------------------------------------------------------
module seven_segment_scan_display_test;
   import sssd_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int KIND_CODES     = 8;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 16;

   // Active-low segment bytes, glyph code 0 in the low byte; 14 and 15 blank.
   localparam logic [127:0] SEGMENT_PATTERNS = {
      8'hFF, 8'hFF, 8'h88, 8'h86, 8'hC1, 8'hBF, 8'h90, 8'h80,
      8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
   };

   typedef struct packed {
      logic [7:0] digit_select;
      logic [7:0] segments;
      logic       rx_on;
      logic       tx_on;
      logic       read_on;
   } scan_frame_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_kind;
   logic [12:0] req_card_id;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_digit_select;
   logic [7:0]  rsp_segments;
   logic        rsp_rx_lamp_on;
   logic        rsp_tx_lamp_on;
   logic        rsp_read_lamp_and_buzzer_on;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [9:0]  csr_wdata;

   // Display model: register copies and display state.
   logic [9:0]  hold_limit_q;
   logic [2:0]  lamp_ticks_q;
   logic [3:0]  version_low_q;
   logic [3:0]  version_high_q;
   logic [3:0]  shown_q    [DIGIT_COUNT];
   logic [3:0]  previous_q [DIGIT_COUNT];
   logic [9:0]  hold_count_q;
   int unsigned scan_q;
   logic [2:0]  rx_count_q;
   logic [2:0]  tx_count_q;
   logic [2:0]  read_count_q;

   scan_frame_type pending_frames[$];
   int          error_count;
   int          idle_cycles;
   bit          gaps_on;
   bit          stalls_on;

   seven_segment_scan_display dut (
      .clock                       (clock),
      .reset                       (reset),
      .req_valid                   (req_valid),
      .req_stall                   (req_stall),
      .req_kind                    (req_kind),
      .req_card_id                 (req_card_id),
      .rsp_valid                   (rsp_valid),
      .rsp_stall                   (rsp_stall),
      .rsp_digit_select            (rsp_digit_select),
      .rsp_segments                (rsp_segments),
      .rsp_rx_lamp_on              (rsp_rx_lamp_on),
      .rsp_tx_lamp_on              (rsp_tx_lamp_on),
      .rsp_read_lamp_and_buzzer_on (rsp_read_lamp_and_buzzer_on),
      .csr_valid                   (csr_valid),
      .csr_ready                   (csr_ready),
      .csr_index                   (csr_index),
      .csr_wdata                   (csr_wdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // ------------------------------------------------------------------------
   // Display model
   // ------------------------------------------------------------------------

   task automatic reset_display_model();
      hold_limit_q   = HOLD_LIMIT_RESET;
      lamp_ticks_q   = LAMP_TICKS_RESET;
      version_low_q  = 4'd0;
      version_high_q = 4'd0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         shown_q[i]    = GLYPH_DASH;
         previous_q[i] = GLYPH_DASH;
      end
      hold_count_q = 10'd0;
      scan_q       = 0;
      rx_count_q   = LAMP_IDLE;
      tx_count_q   = LAMP_IDLE;
      read_count_q = LAMP_IDLE;
   endtask

   // Step one lamp stretcher: lit while its count is below the lamp setting.
   task automatic stretch_lamp(inout logic [2:0] count, output logic lit);
      if (count < lamp_ticks_q) begin
         count = count + 3'd1;
         lit   = 1'b1;
      end else begin
         count = LAMP_IDLE;
         lit   = 1'b0;
      end
   endtask

   // Apply one accepted event to the model; a tick queues the frame it shows.
   task automatic update_display(logic [2:0] kind, logic [12:0] card_id);
      int unsigned number;
      bit          unchanged;
      scan_frame_type frame;
      case (kind)
         KIND_CARD: begin
            // least significant decimal digit lands in digit zero
            number = 32'(card_id);
            for (int i = 0; i < DIGIT_COUNT; i++) begin
               shown_q[i] = 4'(number % 10);
               number     = number / 10;
            end
            hold_count_q = 10'd0;
            read_count_q = 3'd0;
         end
         KIND_RX: rx_count_q = 3'd0;
         KIND_TX: tx_count_q = 3'd0;
         KIND_VERSION: begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
               if (i == 0)
                  shown_q[i] = version_low_q;
               else if (i == 2)
                  shown_q[i] = version_high_q;
               else if (i == 1 || i == 3)
                  shown_q[i] = GLYPH_U;
               else
                  shown_q[i] = GLYPH_BLANK;
            end
         end
         KIND_TICK: begin
            // hold check: count unchanged ticks, blank to dashes past the limit
            unchanged = 1'b1;
            for (int i = 0; i < DIGIT_COUNT; i++)
               if (shown_q[i] != previous_q[i]) unchanged = 1'b0;
            if (unchanged) begin
               if (hold_count_q != HOLD_MAX) hold_count_q = hold_count_q + 10'd1;
               if (hold_count_q > hold_limit_q) begin
                  hold_count_q = hold_limit_q + 10'd1;
                  for (int i = 0; i < DIGIT_COUNT; i++) shown_q[i] = GLYPH_DASH;
               end
            end else begin
               hold_count_q = 10'd0;
            end
            for (int i = 0; i < DIGIT_COUNT; i++) previous_q[i] = shown_q[i];

            stretch_lamp(rx_count_q, frame.rx_on);
            stretch_lamp(tx_count_q, frame.tx_on);
            stretch_lamp(read_count_q, frame.read_on);

            if (scan_q >= DIGIT_COUNT) scan_q = 0;
            frame.digit_select = (scan_q < 8) ? ~(8'd1 << scan_q) : 8'hFF;
            frame.segments     = SEGMENT_PATTERNS[{shown_q[scan_q], 3'b000} +: 8];
            pending_frames.push_back(frame);
            scan_q = (scan_q + 1 < DIGIT_COUNT) ? scan_q + 1 : 0;
         end
         default: ; // unused codes change nothing
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Present one event from a falling edge and hold it until the transfer.
   task automatic send_event(logic [2:0] kind, logic [12:0] card_id);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_card_id <= card_id;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      update_display(kind, card_id);
      @(negedge clock);
   endtask

   task automatic send_ticks(int count);
      repeat (count) send_event(KIND_TICK, 13'($urandom));
   endtask

   // Drop valid and wait for every queued frame, then let the block settle.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(csr_index_type index, logic [9:0] value);
      wait_until_idle();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_HOLD_LIMIT:   hold_limit_q   = value;
         CSR_LAMP_TICKS:   lamp_ticks_q   = value[2:0];
         CSR_VERSION_LOW:  version_low_q  = value[3:0];
         CSR_VERSION_HIGH: version_high_q = value[3:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Narrow register fields go out with random upper bits, which are ignored.
   function automatic logic [9:0] with_noise(logic [3:0] field, int width);
      logic [9:0] word;
      word = 10'($urandom);
      for (int b = 0; b < width; b++) word[b] = field[b];
      return word;
   endfunction

   // One random event; tick_share is the percentage of ticks.
   task automatic send_random_event(int tick_share);
      int pick;
      if ($urandom_range(0, 99) < tick_share) begin
         send_ticks(1);
      end else begin
         pick = $urandom_range(0, 9);
         if (pick < 4)
            send_event(KIND_CARD, 13'($urandom));
         else if (pick < 6)
            send_event(KIND_RX, 13'($urandom));
         else if (pick < 8)
            send_event(KIND_TX, 13'($urandom));
         else if (pick == 8)
            send_event(KIND_VERSION, 13'($urandom));
         else
            send_event(3'($urandom_range(int'(KIND_VERSION) + 1, KIND_CODES - 1)),
                       13'($urandom));
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset settings, card number extremes, every event kind, unused codes.
   task automatic test_reset_and_events();
      send_ticks(4);
      send_event(KIND_VERSION, 13'h1FFF);
      send_ticks(4);
      send_event(KIND_CARD, 13'd0);
      send_ticks(4);
      send_event(KIND_CARD, 13'h1FFF);
      send_event(KIND_RX, 13'd0);
      send_event(KIND_TX, 13'h1FFF);
      send_ticks(4);
      send_event(KIND_CARD, 13'd5678);
      send_event(3'd5, 13'h1FFF);
      send_ticks(2);
      send_event(3'd6, 13'h0AAA);
      send_event(3'd7, 13'h1555);
      send_ticks(3);
   endtask

   // Lamp stretchers at both ends of the setting.
   task automatic test_lamp_lengths();
      logic [2:0] lengths [4];
      lengths = '{3'd0, 3'd7, 3'd1, 3'd6};
      foreach (lengths[n]) begin
         write_register(CSR_LAMP_TICKS, with_noise({1'b0, lengths[n]}, 3));
         send_event(KIND_RX, 13'($urandom));
         send_event(KIND_TX, 13'($urandom));
         send_event(KIND_CARD, 13'($urandom));
         send_ticks(3);
         // restart a lamp while it is still lit
         send_event(KIND_RX, 13'($urandom));
         send_ticks(9);
      end
   endtask

   // Blank on the first repeat, never blank at the top limit, small limit.
   task automatic test_hold_limits();
      write_register(CSR_HOLD_LIMIT, 10'd0);
      send_event(KIND_CARD, 13'd4321);
      send_ticks(8);
      write_register(CSR_HOLD_LIMIT, 10'h3FF);
      send_event(KIND_CARD, 13'd8080);
      send_ticks(1040);
      write_register(CSR_HOLD_LIMIT, 10'd2);
      send_event(KIND_VERSION, 13'd0);
      send_ticks(10);
   endtask

   // Version pattern with blank glyph codes at either position.
   task automatic test_version_glyphs();
      logic [3:0] lows [3];
      logic [3:0] highs [3];
      lows  = '{4'd15, 4'd14, 4'($urandom)};
      highs = '{4'd14, 4'd15, 4'($urandom)};
      foreach (lows[n]) begin
         write_register(CSR_VERSION_LOW, with_noise(lows[n], 4));
         write_register(CSR_VERSION_HIGH, with_noise(highs[n], 4));
         send_event(KIND_VERSION, 13'($urandom));
         send_ticks(5);
      end
   endtask

   // Hold the sender back until the display has returned every frame.
   task automatic test_sender_holdoff();
      repeat (2) begin
         repeat (20) send_random_event(70);
         wait_until_idle();
      end
   endtask

   // Random phases, each under fresh register settings and idling mix.
   task automatic test_random_phases();
      int tick_share;
      for (int phase = 0; phase < 8; phase++) begin
         write_register(CSR_HOLD_LIMIT, ($urandom_range(0, 3) == 0) ?
                        10'($urandom) : 10'($urandom_range(0, 12)));
         write_register(CSR_LAMP_TICKS, with_noise(4'($urandom_range(0, 7)), 3));
         write_register(CSR_VERSION_LOW, with_noise(4'($urandom), 4));
         write_register(CSR_VERSION_HIGH, with_noise(4'($urandom), 4));
         gaps_on    = ($urandom_range(0, 3) != 0);
         stalls_on  = ($urandom_range(0, 3) != 0);
         tick_share = $urandom_range(50, 95);
         repeat (10) send_random_event(tick_share);
      end
   endtask

   // Closing stretch with neither gaps nor stalls.
   task automatic test_full_rate();
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      write_register(CSR_HOLD_LIMIT, 10'd3);
      write_register(CSR_LAMP_TICKS, 10'd2);
      repeat (60) send_random_event(75);
      wait_until_idle();
   endtask

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------

   // Result stall: random bursts with the odd quiet stretch between them.
   initial begin
      int span;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stalls_on && $urandom_range(0, 4) == 0) begin
            span = $urandom_range(1, 8);
            rsp_stall <= 1'b1;
            repeat (span) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 49) == 0) begin
            repeat ($urandom_range(10, 40)) @(negedge clock);
         end
      end
   end

   task automatic compare_field(string name, logic [7:0] wanted, logic [7:0] seen);
      if (wanted !== seen) begin
         $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name,
                  wanted, seen);
         error_count++;
      end
   endtask

   // Check each result transfer against the oldest predicted frame.
   always @(posedge clock) begin
      scan_frame_type wanted;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_frames.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %02h %02h %b%b%b",
                     $time, rsp_digit_select, rsp_segments, rsp_rx_lamp_on,
                     rsp_tx_lamp_on, rsp_read_lamp_and_buzzer_on);
            error_count++;
         end else begin
            wanted = pending_frames.pop_front();
            compare_field("digit_select", wanted.digit_select, rsp_digit_select);
            compare_field("segments", wanted.segments, rsp_segments);
            compare_field("rx_lamp_on", 8'(wanted.rx_on), 8'(rsp_rx_lamp_on));
            compare_field("tx_lamp_on", 8'(wanted.tx_on), 8'(rsp_tx_lamp_on));
            compare_field("read_lamp_and_buzzer_on", 8'(wanted.read_on),
                          8'(rsp_read_lamp_and_buzzer_on));
         end
      end
   end

   // Watchdog: end the run once nothing has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("seven_segment_scan_display_test: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_kind    = KIND_TICK;
      req_card_id = 13'd0;
      csr_valid   = 1'b0;
      csr_index   = CSR_HOLD_LIMIT;
      csr_wdata   = 10'd0;
      error_count = 0;
      idle_cycles = 0;
      gaps_on     = 1'b1;
      stalls_on   = 1'b1;
      reset_display_model();

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_and_events();
      test_lamp_lengths();
      test_hold_limits();
      test_version_glyphs();
      test_sender_holdoff();
      test_random_phases();
      test_full_rate();

      // let any stray result show itself before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("seven_segment_scan_display_test: done, clean");
      else
         $display("seven_segment_scan_display_test: done, errors");
      $finish;
   end

endmodule

>>> files.f
rtl/sssd_pkg.sv
rtl/seven_segment_scan_display.sv
tb/sv/seven_segment_scan_display_test.sv
